FILE: rtl/core/nac_pkg.sv
package nac_pkg;

    localparam int APB_AW = 4;

    localparam logic OP_REPORT   = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    localparam logic [14:0] RADIUS_RST    = 15'd1200;
    localparam logic [19:0] WINDOW_RST    = 20'd2700;
    localparam logic [15:0] THRESHOLD_RST = 16'd42598;
    localparam logic [7:0]  MIN_CH_RST    = 8'd2;

    typedef enum logic [1:0] {
        REG_RADIUS_DM       = 2'd0,
        REG_WINDOW_SEC      = 2'd1,
        REG_ALARM_THRESHOLD = 2'd2,
        REG_MIN_CHANNELS    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [14:0] radius_dm;
        logic [19:0] window_sec;
        logic [15:0] alarm_threshold;
        logic [7:0]  min_channels;
    } t_cfg;

    typedef struct packed {
        logic [63:0]        id_hi;
        logic [63:0]        id_lo;
        logic signed [15:0] x_dm;
        logic signed [15:0] y_dm;
        logic [31:0]        rtime;
        logic               anomalous;
    } t_entry;

    typedef struct packed {
        logic        valid;
        logic        busy;
        logic        hit;
        logic        match;
        logic [63:0] id_hi;
        logic [55:0] id_lo;
    } t_test_res;

endpackage

FILE: rtl/core/nac_ram.sv
module nac_ram #(
    parameter int WIDTH = 193,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/nac_cfg.sv
module nac_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nac_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output nac_pkg::t_cfg              o_cfg
);

    nac_pkg::t_cfg    r_cfg;
    nac_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign reg_idx = nac_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_dm       <= nac_pkg::RADIUS_RST;
            r_cfg.window_sec      <= nac_pkg::WINDOW_RST;
            r_cfg.alarm_threshold <= nac_pkg::THRESHOLD_RST;
            r_cfg.min_channels    <= nac_pkg::MIN_CH_RST;
        end else if (wr_en) begin
            case (reg_idx)
                nac_pkg::REG_RADIUS_DM:       r_cfg.radius_dm       <= pwdata[14:0];
                nac_pkg::REG_WINDOW_SEC:      r_cfg.window_sec      <= pwdata[19:0];
                nac_pkg::REG_ALARM_THRESHOLD: r_cfg.alarm_threshold <= pwdata[15:0];
                nac_pkg::REG_MIN_CHANNELS:    r_cfg.min_channels    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nac_pkg::REG_RADIUS_DM:       prdata = {17'b0, r_cfg.radius_dm};
            nac_pkg::REG_WINDOW_SEC:      prdata = {12'b0, r_cfg.window_sec};
            nac_pkg::REG_ALARM_THRESHOLD: prdata = {16'b0, r_cfg.alarm_threshold};
            nac_pkg::REG_MIN_CHANNELS:    prdata = {24'b0, r_cfg.min_channels};
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/nac_entry_test.sv
module nac_entry_test #(
    parameter int AW = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [AW-1:0]       i_addr,
    input  nac_pkg::t_entry     i_entry,
    input  logic [63:0]         i_key_hi,
    input  logic [63:0]         i_key_lo,
    input  logic [31:0]         i_now,
    input  logic [19:0]         i_window,
    input  logic [29:0]         i_r2,
    output logic [AW-1:0]       o_addr,
    output nac_pkg::t_test_res  o_res
);

    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic [31:0]        dt;
    logic               time_ok;
    logic [31:0]        d2;

    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_addr;
    logic [30:0]        r_s1_x2;
    logic [30:0]        r_s1_y2;
    logic               r_s1_ok;
    logic               r_s1_match;
    logic [63:0]        r_s1_id_hi;
    logic [55:0]        r_s1_id_lo;

    logic               r_s2_valid;
    logic [AW-1:0]      r_s2_addr;
    logic               r_s2_hit;
    logic               r_s2_match;
    logic [63:0]        r_s2_id_hi;
    logic [55:0]        r_s2_id_lo;

    assign sq_x    = i_entry.x_dm * i_entry.x_dm;
    assign sq_y    = i_entry.y_dm * i_entry.y_dm;
    assign dt      = (i_now >= i_entry.rtime) ? (i_now - i_entry.rtime)
                                              : (i_entry.rtime - i_now);
    assign time_ok = dt <= {12'b0, i_window};
    assign d2      = {1'b0, r_s1_x2} + {1'b0, r_s1_y2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_addr  <= i_addr;
        r_s1_x2    <= sq_x[30:0];
        r_s1_y2    <= sq_y[30:0];
        r_s1_ok    <= time_ok & i_entry.anomalous;
        r_s1_match <= (i_entry.id_hi == i_key_hi) && (i_entry.id_lo == i_key_lo);
        r_s1_id_hi <= i_entry.id_hi;
        r_s1_id_lo <= i_entry.id_lo[63:8];

        r_s2_addr  <= r_s1_addr;
        r_s2_hit   <= r_s1_ok && (d2 <= {2'b0, i_r2});
        r_s2_match <= r_s1_match;
        r_s2_id_hi <= r_s1_id_hi;
        r_s2_id_lo <= r_s1_id_lo;
    end

    assign o_addr      = r_s2_addr;
    assign o_res.valid = r_s2_valid;
    assign o_res.busy  = r_s1_valid | r_s2_valid;
    assign o_res.hit   = r_s2_hit;
    assign o_res.match = r_s2_match;
    assign o_res.id_hi = r_s2_id_hi;
    assign o_res.id_lo = r_s2_id_lo;

endmodule

FILE: rtl/core/neighbor_alarm_corroborator.sv
// Each request scans the stored entries, one RAM entry read per cycle, then drains the
// entry test pipeline and finishes; an empty table skips the reads and an evaluate
// with too few concordant channels skips scan and drain. New requests are held off
// by o_stall until the block is back in idle.
// A result waits in the output register and a stalled result holds the block.
// Reset clears entry count, ring head, alarm and handshake state, not the table RAM.
module neighbor_alarm_corroborator #(
    parameter int NEIGHBORS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nac_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,

    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_operation,
    input  logic [63:0]                i_node_id_hi,
    input  logic [63:0]                i_node_id_lo,
    input  logic signed [15:0]         i_rel_x_dm,
    input  logic signed [15:0]         i_rel_y_dm,
    input  logic [31:0]                i_report_time,
    input  logic                       i_neighbor_anomalous,
    input  logic [15:0]                i_local_score,
    input  logic [7:0]                 i_concordant_channels,
    input  logic [31:0]                i_now_time,

    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_alarm_decision,
    output logic                       o_alarm_latched,
    output logic [15:0]                o_corroborated_score,
    output logic [4:0]                 o_corroborator_count,
    output logic [63:0]                o_primary_id_hi,
    output logic [55:0]                o_primary_id_lo
);

    localparam int AW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int CW = $clog2(NEIGHBORS + 1);
    localparam int HW = (CW > 5) ? CW : 5;
    localparam int EW = $bits(nac_pkg::t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [AW+1:0] s;
        s = (AW+2)'(head) + (AW+2)'(idx);
        if (s >= (AW+2)'(NEIGHBORS)) begin
            s = s - (AW+2)'(NEIGHBORS);
        end
        return s[AW-1:0];
    endfunction

    nac_pkg::t_cfg      cfg;
    nac_pkg::t_test_res res;
    nac_pkg::t_entry    rd_entry;
    nac_pkg::t_entry    wr_entry;
    logic [EW-1:0]      rd_data;
    logic [AW-1:0]      res_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [29:0]        radius_sq;
    logic               accept;
    logic               out_load;
    logic               no_corr;
    logic               decision;

    t_state             r_state;
    logic               r_op;
    logic [63:0]        r_key_hi;
    logic [63:0]        r_key_lo;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [31:0]        r_rtime;
    logic               r_anom;
    logic [15:0]        r_score;
    logic [31:0]        r_now;
    logic [29:0]        r_r2;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_head;
    logic               r_rd_valid;
    logic [AW-1:0]      r_rd_addr;
    logic [HW-1:0]      r_hits;
    logic               r_have_primary;
    logic [63:0]        r_p_hi;
    logic [55:0]        r_p_lo;
    logic               r_found;
    logic [AW-1:0]      r_found_addr;
    logic               r_alarm;

    logic               r_out_valid;
    logic               r_out_decision;
    logic               r_out_latched;
    logic [15:0]        r_out_score;
    logic [4:0]         r_out_count;
    logic [63:0]        r_out_p_hi;
    logic [55:0]        r_out_p_lo;

    nac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign rd_addr = phys(r_head, r_idx);
    assign wr_en   = (r_state == ST_FINISH) && (r_op == nac_pkg::OP_REPORT);
    assign wr_addr = r_found ? r_found_addr :
                     (r_count < CW'(NEIGHBORS)) ? phys(r_head, r_count) : r_head;

    assign wr_entry.id_hi     = r_key_hi;
    assign wr_entry.id_lo     = r_key_lo;
    assign wr_entry.x_dm      = r_x;
    assign wr_entry.y_dm      = r_y;
    assign wr_entry.rtime     = r_rtime;
    assign wr_entry.anomalous = r_anom;

    nac_ram #(
        .WIDTH (EW),
        .DEPTH (NEIGHBORS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_entry = nac_pkg::t_entry'(rd_data);

    nac_entry_test #(
        .AW (AW)
    ) u_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_valid),
        .i_addr   (r_rd_addr),
        .i_entry  (rd_entry),
        .i_key_hi (r_key_hi),
        .i_key_lo (r_key_lo),
        .i_now    (r_now),
        .i_window (cfg.window_sec),
        .i_r2     (r_r2),
        .o_addr   (res_addr),
        .o_res    (res)
    );

    assign radius_sq = {15'b0, cfg.radius_dm} * {15'b0, cfg.radius_dm};
    assign accept    = (r_state == ST_IDLE) && i_valid;
    assign out_load  = (r_state == ST_FINISH) && (r_op == nac_pkg::OP_EVALUATE)
                       && (!r_out_valid || !i_stall);
    assign no_corr   = (r_hits == '0);
    assign decision  = !no_corr && (r_score >= cfg.alarm_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_alarm     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            if (res.valid) begin
                if (res.match) begin
                    r_found      <= 1'b1;
                    r_found_addr <= res_addr;
                end
                if (res.hit) begin
                    r_hits <= r_hits + 1'b1;
                    if (!r_have_primary) begin
                        r_have_primary <= 1'b1;
                        r_p_hi         <= res.id_hi;
                        r_p_lo         <= res.id_lo;
                    end
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_op           <= i_operation;
                        r_key_hi       <= i_node_id_hi;
                        r_key_lo       <= i_node_id_lo;
                        r_x            <= i_rel_x_dm;
                        r_y            <= i_rel_y_dm;
                        r_rtime        <= i_report_time;
                        r_anom         <= i_neighbor_anomalous;
                        r_score        <= i_local_score;
                        r_now          <= i_now_time;
                        r_r2           <= radius_sq;
                        r_idx          <= '0;
                        r_hits         <= '0;
                        r_have_primary <= 1'b0;
                        r_p_hi         <= '0;
                        r_p_lo         <= '0;
                        r_found        <= 1'b0;
                        if (i_operation == nac_pkg::OP_EVALUATE
                            && i_concordant_channels < cfg.min_channels) begin
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_idx < r_count) begin
                        r_rd_valid <= 1'b1;
                        r_rd_addr  <= rd_addr;
                        r_idx      <= r_idx + 1'b1;
                    end else begin
                        r_rd_valid <= 1'b0;
                        r_state    <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_rd_valid && !res.busy && !res.valid) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (r_op == nac_pkg::OP_REPORT) begin
                        if (!r_found) begin
                            if (r_count < CW'(NEIGHBORS)) begin
                                r_count <= r_count + 1'b1;
                            end else if (r_head == AW'(NEIGHBORS - 1)) begin
                                r_head <= '0;
                            end else begin
                                r_head <= r_head + 1'b1;
                            end
                        end
                        r_state <= ST_IDLE;
                    end else if (out_load) begin
                        r_out_valid    <= 1'b1;
                        r_out_decision <= decision;
                        r_out_latched  <= no_corr ? 1'b0 : (decision | r_alarm);
                        r_out_score    <= no_corr ? {2'b0, r_score[15:2]} : r_score;
                        r_out_count    <= r_hits[4:0];
                        r_out_p_hi     <= r_p_hi;
                        r_out_p_lo     <= r_p_lo;
                        r_alarm        <= no_corr ? 1'b0 : (decision | r_alarm);
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall              = (r_state != ST_IDLE);
    assign o_valid              = r_out_valid;
    assign o_alarm_decision     = r_out_decision;
    assign o_alarm_latched      = r_out_latched;
    assign o_corroborated_score = r_out_score;
    assign o_corroborator_count = r_out_count;
    assign o_primary_id_hi      = r_out_p_hi;
    assign o_primary_id_lo      = r_out_p_lo;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NEIGHBORS))
        else $error("entry count exceeds table depth");

    a_head_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CW'(NEIGHBORS) |-> r_head == '0)
        else $error("ring head moved before table filled");

    a_no_primary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_corroborator_count == 5'd0 |->
            o_primary_id_hi == 64'd0 && o_primary_id_lo == 56'd0)
        else $error("primary id set without corroborators");

    a_decision_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_alarm_decision |-> o_alarm_latched)
        else $error("alarm decision without latched alarm");

endmodule

FILE: verif/neighbor_alarm_corroborator_tb.sv
`timescale 1ns / 1ps

module neighbor_alarm_corroborator_tb;

    localparam int NEIGHBORS       = 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int POOL            = 24;
    localparam int QUIET_LIMIT     = 1000;
    localparam logic [31:0] T0     = 32'h1000_0000;

    typedef struct {
        logic               op;
        logic [63:0]        id_hi;
        logic [63:0]        id_lo;
        logic signed [15:0] x_dm;
        logic signed [15:0] y_dm;
        logic [31:0]        rtime;
        logic               anomalous;
        logic [15:0]        score;
        logic [7:0]         chans;
        logic [31:0]        now;
    } t_txn;

    typedef struct {
        logic        decision;
        logic        latched;
        logic [15:0] score;
        logic [4:0]  count;
        logic [63:0] pid_hi;
        logic [55:0] pid_lo;
    } t_verdict;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} t_stall_mode;

    class alarm_scoreboard;
        nac_pkg::t_entry table_q[$];
        t_verdict        pending_alarms[$];
        nac_pkg::t_cfg   cfg;
        bit              alarm;
        int              errors;

        function new();
            cfg.radius_dm       = nac_pkg::RADIUS_RST;
            cfg.window_sec      = nac_pkg::WINDOW_RST;
            cfg.alarm_threshold = nac_pkg::THRESHOLD_RST;
            cfg.min_channels    = nac_pkg::MIN_CH_RST;
            alarm  = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(nac_pkg::t_reg_idx idx, logic [31:0] val);
            case (idx)
                nac_pkg::REG_RADIUS_DM:       cfg.radius_dm       = val[14:0];
                nac_pkg::REG_WINDOW_SEC:      cfg.window_sec      = val[19:0];
                nac_pkg::REG_ALARM_THRESHOLD: cfg.alarm_threshold = val[15:0];
                nac_pkg::REG_MIN_CHANNELS:    cfg.min_channels    = val[7:0];
                default: ;
            endcase
        endfunction

        function void note_txn(t_txn tx);
            nac_pkg::t_entry e;
            t_verdict        v;
            int              hit;
            int unsigned     cnt;
            longint          x, y, r2;
            logic [31:0]     dt;
            if (tx.op == nac_pkg::OP_REPORT) begin
                e.id_hi     = tx.id_hi;
                e.id_lo     = tx.id_lo;
                e.x_dm      = tx.x_dm;
                e.y_dm      = tx.y_dm;
                e.rtime     = tx.rtime;
                e.anomalous = tx.anomalous;
                hit = -1;
                foreach (table_q[i]) begin
                    if (hit < 0 && table_q[i].id_hi == tx.id_hi && table_q[i].id_lo == tx.id_lo)
                        hit = i;
                end
                if (hit >= 0) begin
                    table_q[hit] = e;
                end else begin
                    if (table_q.size() == NEIGHBORS)
                        void'(table_q.pop_front());
                    table_q.push_back(e);
                end
                return;
            end
            v.decision = 1'b0;
            v.pid_hi   = '0;
            v.pid_lo   = '0;
            cnt = 0;
            if (tx.chans >= cfg.min_channels) begin
                r2 = longint'(cfg.radius_dm) * longint'(cfg.radius_dm);
                foreach (table_q[i]) begin
                    x  = $signed(table_q[i].x_dm);
                    y  = $signed(table_q[i].y_dm);
                    dt = (tx.now >= table_q[i].rtime) ? tx.now - table_q[i].rtime
                                                      : table_q[i].rtime - tx.now;
                    if (x * x + y * y <= r2 && dt <= cfg.window_sec && table_q[i].anomalous) begin
                        if (cnt == 0) begin
                            v.pid_hi = table_q[i].id_hi;
                            v.pid_lo = table_q[i].id_lo[63:8];
                        end
                        cnt++;
                    end
                end
            end
            if (cnt == 0) begin
                v.score = tx.score >> 2;
                alarm   = 1'b0;
            end else begin
                v.score = tx.score;
                if (tx.score >= cfg.alarm_threshold) begin
                    v.decision = 1'b1;
                    alarm      = 1'b1;
                end
            end
            v.latched = alarm;
            v.count   = 5'(cnt);
            pending_alarms.push_back(v);
        endfunction

        function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(t_verdict got);
            t_verdict want;
            if (pending_alarms.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual score %h count %0d",
                         $time, got.score, got.count);
                errors++;
                return;
            end
            want = pending_alarms.pop_front();
            cmp_field("alarm_decision", 64'(want.decision), 64'(got.decision));
            cmp_field("alarm_latched", 64'(want.latched), 64'(got.latched));
            cmp_field("corroborated_score", 64'(want.score), 64'(got.score));
            cmp_field("corroborator_count", 64'(want.count), 64'(got.count));
            cmp_field("primary_id_hi", want.pid_hi, got.pid_hi);
            cmp_field("primary_id_lo", 64'(want.pid_lo), 64'(got.pid_lo));
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [nac_pkg::APB_AW-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_operation;
    logic [63:0]                i_node_id_hi;
    logic [63:0]                i_node_id_lo;
    logic signed [15:0]         i_rel_x_dm;
    logic signed [15:0]         i_rel_y_dm;
    logic [31:0]                i_report_time;
    logic                       i_neighbor_anomalous;
    logic [15:0]                i_local_score;
    logic [7:0]                 i_concordant_channels;
    logic [31:0]                i_now_time;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic                       o_alarm_decision;
    logic                       o_alarm_latched;
    logic [15:0]                o_corroborated_score;
    logic [4:0]                 o_corroborator_count;
    logic [63:0]                o_primary_id_hi;
    logic [55:0]                o_primary_id_lo;

    alarm_scoreboard sb = new();
    t_verdict        observed;
    logic [63:0]     pool_hi [POOL];
    logic [63:0]     pool_lo [POOL];
    logic [31:0]     time_base = T0;
    int              burst_left = 0;
    int unsigned     quiet_cycles = 0;
    int unsigned     mode_timer = 0;
    int unsigned     stall_hold = 0;
    t_stall_mode     stall_mode = STALL_NONE;

    neighbor_alarm_corroborator #(
        .NEIGHBORS(NEIGHBORS)
    ) i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_operation           (i_operation),
        .i_node_id_hi          (i_node_id_hi),
        .i_node_id_lo          (i_node_id_lo),
        .i_rel_x_dm            (i_rel_x_dm),
        .i_rel_y_dm            (i_rel_y_dm),
        .i_report_time         (i_report_time),
        .i_neighbor_anomalous  (i_neighbor_anomalous),
        .i_local_score         (i_local_score),
        .i_concordant_channels (i_concordant_channels),
        .i_now_time            (i_now_time),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_alarm_decision      (o_alarm_decision),
        .o_alarm_latched       (o_alarm_latched),
        .o_corroborated_score  (o_corroborated_score),
        .o_corroborator_count  (o_corroborator_count),
        .o_primary_id_hi       (o_primary_id_hi),
        .o_primary_id_lo       (o_primary_id_lo)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern, mode redrawn at random from time to time
    always @(posedge i_clk) begin
        mode_timer <= mode_timer + 1;
        if (mode_timer % 300 == 299)
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        if (stall_hold != 0) begin
            i_stall    <= 1'b1;
            stall_hold <= stall_hold - 1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 2) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_hold <= $urandom_range(4, 30);
                        i_stall    <= 1'b1;
                    end else begin
                        i_stall <= 1'b0;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            observed.decision = o_alarm_decision;
            observed.latched  = o_alarm_latched;
            observed.score    = o_corroborated_score;
            observed.count    = o_corroborator_count;
            observed.pid_hi   = o_primary_id_hi;
            observed.pid_lo   = o_primary_id_lo;
            sb.check_verdict(observed);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** neighbor_alarm_corroborator: FAILED **");
            $finish;
        end
    end

    function automatic logic [15:0] rand_offset(int r);
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'(r);
            3:       return 16'(-r);
            4, 5:    return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2 * r)) - r);
        endcase
    endfunction

    function automatic logic [31:0] rand_time(int w);
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return time_base + 32'($urandom_range(0, 2 * w + 4)) - 32'(w + 2);
    endfunction

    function automatic t_txn rand_txn();
        t_txn tx;
        int   k, sel, s, m;
        tx.op = ($urandom_range(0, 99) < 40) ? nac_pkg::OP_EVALUATE : nac_pkg::OP_REPORT;
        k = $urandom_range(0, POOL - 1);
        tx.id_hi = pool_hi[k];
        tx.id_lo = pool_lo[k];
        if ($urandom_range(0, 9) == 0) begin
            tx.id_hi = {$urandom, $urandom};
            tx.id_lo = {$urandom, $urandom};
        end
        tx.x_dm      = rand_offset(int'(sb.cfg.radius_dm));
        tx.y_dm      = rand_offset(int'(sb.cfg.radius_dm));
        tx.rtime     = rand_time(int'(sb.cfg.window_sec));
        tx.now       = rand_time(int'(sb.cfg.window_sec));
        tx.anomalous = ($urandom_range(0, 9) < 7);
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            tx.score = 16'($urandom);
        end else if (sel < 7) begin
            s = int'(sb.cfg.alarm_threshold) + int'($urandom_range(0, 4)) - 2;
            tx.score = (s < 0) ? 16'd0 : (s > 65535) ? 16'hFFFF : 16'(s);
        end else if (sel == 7) begin
            tx.score = 16'h0000;
        end else if (sel == 8) begin
            tx.score = 16'hFFFF;
        end else begin
            tx.score = 16'($urandom_range(0, 15));
        end
        m = int'(sb.cfg.min_channels);
        sel = $urandom_range(0, 9);
        if (sel < 7)
            s = m + int'($urandom_range(0, 3));
        else if (sel < 9)
            s = m - 1 - int'($urandom_range(0, 2));
        else
            s = $urandom_range(0, 255);
        tx.chans = (s < 0) ? 8'd0 : (s > 255) ? 8'hFF : 8'(s);
        return tx;
    endfunction

    task automatic push_txn(t_txn tx);
        int gap;
        i_valid               <= 1'b1;
        i_operation           <= tx.op;
        i_node_id_hi          <= tx.id_hi;
        i_node_id_lo          <= tx.id_lo;
        i_rel_x_dm            <= tx.x_dm;
        i_rel_y_dm            <= tx.y_dm;
        i_report_time         <= tx.rtime;
        i_neighbor_anomalous  <= tx.anomalous;
        i_local_score         <= tx.score;
        i_concordant_channels <= tx.chans;
        i_now_time            <= tx.now;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_txn(tx);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            case ($urandom_range(0, 2))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 40);
            endcase
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic report_at(logic [63:0] hi, logic [63:0] lo, logic [15:0] x,
                             logic [15:0] y, logic [31:0] t, logic anom);
        t_txn tx;
        tx = rand_txn();
        tx.op        = nac_pkg::OP_REPORT;
        tx.id_hi     = hi;
        tx.id_lo     = lo;
        tx.x_dm      = x;
        tx.y_dm      = y;
        tx.rtime     = t;
        tx.anomalous = anom;
        push_txn(tx);
    endtask

    task automatic evaluate_at(logic [15:0] score, logic [7:0] chans, logic [31:0] now);
        t_txn tx;
        tx = rand_txn();
        tx.op    = nac_pkg::OP_EVALUATE;
        tx.score = score;
        tx.chans = chans;
        tx.now   = now;
        push_txn(tx);
    endtask

    task automatic apb_write(nac_pkg::t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // a report leaves no result behind, so allow a full table walk after the last one
    task automatic wait_drained();
        while (sb.pending_alarms.size() != 0)
            @(posedge i_clk);
        repeat (NEIGHBORS + 12) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] cfg_top [4];
        logic [31:0] val;
        int          phase, k, n;
        cfg_top = '{32'd32767, 32'd1048575, 32'd65535, 32'd255};

        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        i_valid               <= 1'b0;
        i_operation           <= nac_pkg::OP_REPORT;
        i_node_id_hi          <= '0;
        i_node_id_lo          <= '0;
        i_rel_x_dm            <= '0;
        i_rel_y_dm            <= '0;
        i_report_time         <= '0;
        i_neighbor_anomalous  <= 1'b0;
        i_local_score         <= '0;
        i_concordant_channels <= '0;
        i_now_time            <= '0;

        // id pool: random ids, ids differing only in byte 15, NUL-padded ids
        for (k = 0; k < POOL; k++) begin
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
            if (k % 3 == 1) begin
                pool_hi[k] = pool_hi[k-1];
                pool_lo[k] = {pool_lo[k-1][63:8], 8'($urandom)};
            end else if (k % 3 == 2) begin
                pool_lo[k] = {8'($urandom), 56'd0};
            end
        end
        pool_hi[3]        = '0;
        pool_lo[3]        = '0;
        pool_hi[POOL - 1] = '1;
        pool_lo[POOL - 1] = '1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset configuration
        evaluate_at(16'hFFFF, 8'd255, T0);
        report_at(64'd0, 64'd0, 16'd0, 16'd0, T0, 1'b1);
        report_at('1, '1, 16'd1200, 16'd0, T0 + 32'd2700, 1'b1);
        report_at(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'h8000, 16'h8000,
                  T0, 1'b1);
        report_at(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3211, 16'h7FFF, 16'h7FFF,
                  T0, 1'b1);
        report_at(64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 16'd0, 16'hFB50,
                  T0 - 32'd2700, 1'b0);
        report_at(64'h6E6F_6465_2D37_0000, 64'd0, 16'd848, 16'd848, T0 - 32'd1, 1'b1);
        evaluate_at(16'hFFFF, 8'd255, T0);
        evaluate_at(16'd42597, 8'd2, T0);
        evaluate_at(16'd42598, 8'd2, T0 + 32'd1);
        evaluate_at(16'hFFFF, 8'd1, T0);
        evaluate_at(16'd0, 8'd2, T0);
        report_at(64'd0, 64'd0, 16'd0, 16'd0, T0, 1'b0);
        evaluate_at(16'hFFFF, 8'd2, T0);
        evaluate_at(16'd3, 8'd0, T0 + 32'd2701);
        evaluate_at(16'hFFFF, 8'd2, T0 + 32'd5401);
        report_at(64'hC0FF_EE00_1234_5678, 64'h8765_4321_00EE_FFC0, 16'd0, 16'd0,
                  32'hFFFF_FFFF, 1'b1);
        evaluate_at(16'hFFFF, 8'd2, 32'd0);
        evaluate_at(16'hFFFF, 8'd2, 32'hFFFF_F573);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                i_valid <= 1'b0;
                wait_drained();
                for (k = 0; k < 4; k++) begin
                    if (phase == 1) begin
                        val = 32'd0;
                    end else if (phase == 2) begin
                        val = cfg_top[k];
                    end else begin
                        case ($urandom_range(0, 5))
                            0: val = 32'd0;
                            1: val = cfg_top[k];
                            2: val = (nac_pkg::t_reg_idx'(k) == nac_pkg::REG_RADIUS_DM)
                                         ? 32'(nac_pkg::RADIUS_RST)
                                   : (nac_pkg::t_reg_idx'(k) == nac_pkg::REG_WINDOW_SEC)
                                         ? 32'(nac_pkg::WINDOW_RST)
                                   : (nac_pkg::t_reg_idx'(k) == nac_pkg::REG_ALARM_THRESHOLD)
                                         ? 32'(nac_pkg::THRESHOLD_RST)
                                   : 32'(nac_pkg::MIN_CH_RST);
                            default: val = $urandom_range(0, cfg_top[k] >> $urandom_range(0, 12));
                        endcase
                    end
                    apb_write(nac_pkg::t_reg_idx'(k), val);
                end
                time_base = (phase % 4 == 3) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                             : $urandom;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                push_txn(rand_txn());
        end

        i_valid <= 1'b0;
        wait_drained();
        if (sb.errors == 0 && sb.pending_alarms.size() == 0) begin
            $display("** neighbor_alarm_corroborator: PASSED **");
        end else begin
            $display("** neighbor_alarm_corroborator: FAILED **");
        end
        $finish;
    end

endmodule
